@@ design/csvt_pkg.sv @@
// Shared types and constants for the CSV field tokenizer.
// Used by csvt_ctrl, csvt_dp, csv_field_tokenizer and csvt_checker; depends on nothing.
`default_nettype none

package csvt_pkg;

    localparam int BLANK_DEPTH = 32;
    localparam int MAX_FIELDS  = 64;

    localparam int BLANK_CW    = $clog2(BLANK_DEPTH + 1);
    localparam int BLANK_IW    = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;
    localparam int FIELD_W     = $clog2(MAX_FIELDS);
    localparam int OUT_FIELD_W = 6;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HOLD_CR,
        OP_QUOTE,
        OP_BLANK,
        OP_BYTE,
        OP_BLANK_OUT,
        OP_FIELD_END,
        OP_ROW_END,
        OP_LINE_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   last;
    } dp_cmd_t;

    typedef struct packed {
        logic eoi;
        logic is_lf;
        logic is_cr;
        logic is_quote;
        logic is_comma;
        logic is_blank;
        logic cr_phase;
        logic cr_last;
        logic quoted;
        logic field_started;
        logic blanks_pending;
        logic blank_done;
        logic line_has_bytes;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ design/csvt_ctrl.sv @@
// Sequencer for the CSV field tokenizer: decodes the current character
// and steps the datapath. Depends on csvt_pkg.
`default_nettype none

module csvt_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    input  csvt_pkg::dp_status_t   status,
    output logic                   s_tready,
    output csvt_pkg::dp_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROC  = 2'd1;
    localparam logic [1:0] ST_BLANK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = csvt_pkg::OP_NONE;
        cmd.last   = 1'b0;
        s_tready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = csvt_pkg::OP_LOAD;
                    state_next = ST_PROC;
                end
            end
            ST_PROC: begin
                priority if (!status.cr_phase && (status.eoi || status.is_lf)) begin
                    if (!status.line_has_bytes) begin
                        cmd.op     = csvt_pkg::OP_LINE_CLEAR;
                        state_next = ST_IDLE;
                    end else if (status.out_free) begin
                        cmd.op     = csvt_pkg::OP_ROW_END;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (!status.cr_phase && status.is_cr) begin
                    cmd.op     = csvt_pkg::OP_HOLD_CR;
                    state_next = ST_IDLE;
                end else if (!status.cr_phase && status.is_quote) begin
                    cmd.op     = csvt_pkg::OP_QUOTE;
                    state_next = ST_IDLE;
                end else if (!status.cr_phase && status.is_comma && !status.quoted) begin
                    if (status.out_free) begin
                        cmd.op     = csvt_pkg::OP_FIELD_END;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (!status.cr_phase && status.is_blank) begin
                    cmd.op     = csvt_pkg::OP_BLANK;
                    state_next = ST_IDLE;
                end else if (status.field_started && status.blanks_pending) begin
                    // held blanks go out ahead of this byte
                    state_next = ST_BLANK;
                end else if (status.out_free) begin
                    cmd.op     = csvt_pkg::OP_BYTE;
                    cmd.last   = status.cr_phase ? status.cr_last : 1'b1;
                    state_next = status.cr_phase ? ST_PROC : ST_IDLE;
                end else begin
                    // result register still occupied
                end
            end
            ST_BLANK: begin
                if (status.out_free) begin
                    cmd.op = csvt_pkg::OP_BLANK_OUT;
                    if (status.blank_done) begin
                        state_next = ST_PROC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/csvt_dp.sv @@
// Datapath of the CSV field tokenizer: line/field state, blank store,
// item registers and the output register. Depends on csvt_pkg.
`default_nettype none

module csvt_dp (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire  [7:0]             in_byte,
    input  wire                    in_eoi,
    input  csvt_pkg::dp_cmd_t      cmd,
    output csvt_pkg::dp_status_t   status,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [15:0]            m_tdata,
    output logic [3:0]             m_tuser,
    output logic                   m_tlast
);

    localparam int CW = csvt_pkg::BLANK_CW;
    localparam int IW = csvt_pkg::BLANK_IW;
    localparam int FW = csvt_pkg::FIELD_W;

    // item and current character
    logic [7:0]     item_reg, item_next;
    logic           eoi_reg, eoi_next;
    logic [7:0]     cur_reg, cur_next;
    logic           crph_reg, crph_next;

    // line / field state
    logic           quoted_reg, quoted_next;
    logic           started_reg, started_next;
    logic [CW-1:0]  bcnt_reg, bcnt_next;
    logic [IW-1:0]  bidx_reg, bidx_next;
    logic           held_cr_reg, held_cr_next;
    logic           lhb_reg, lhb_next;
    logic           hdr_seen_reg, hdr_seen_next;
    logic [FW-1:0]  fcnt_reg, fcnt_next;
    logic           lost_reg, lost_next;

    // output register
    logic           ovalid_reg, ovalid_next;
    logic [1:0]     okind_reg;
    logic [7:0]     obyte_reg;
    logic [5:0]     ofield_reg;
    logic           ohdr_reg;
    logic           oovf_reg;
    logic           olast_reg;

    logic           blank_mem [csvt_pkg::BLANK_DEPTH];
    logic           store_wr;
    logic           emit;
    logic [1:0]     emit_kind;
    logic [7:0]     emit_byte;
    logic           emit_ovf;
    logic           out_free;
    logic           load_crph;
    logic           blank_rd_reg;

    assign out_free  = !ovalid_reg || m_tready;
    assign load_crph = !in_eoi && (in_byte != csvt_pkg::CH_LF) && held_cr_reg;

    always_comb begin
        status.eoi            = eoi_reg;
        status.is_lf          = (cur_reg == csvt_pkg::CH_LF);
        status.is_cr          = (cur_reg == csvt_pkg::CH_CR);
        status.is_quote       = (cur_reg == csvt_pkg::CH_QUOTE);
        status.is_comma       = (cur_reg == csvt_pkg::CH_COMMA);
        status.is_blank       = (cur_reg == csvt_pkg::CH_SPACE) ||
                                (cur_reg == csvt_pkg::CH_TAB);
        status.cr_phase       = crph_reg;
        // the released CR ends the step if the pending byte yields nothing
        status.cr_last        = (item_reg == csvt_pkg::CH_CR) ||
                                (item_reg == csvt_pkg::CH_QUOTE) ||
                                (item_reg == csvt_pkg::CH_SPACE) ||
                                (item_reg == csvt_pkg::CH_TAB);
        status.quoted         = quoted_reg;
        status.field_started  = started_reg;
        status.blanks_pending = (bcnt_reg != '0);
        status.blank_done     = ((CW'(bidx_reg) + CW'(1)) == bcnt_reg);
        status.line_has_bytes = lhb_reg;
        status.out_free       = out_free;
    end

    always_comb begin
        item_next     = item_reg;
        eoi_next      = eoi_reg;
        cur_next      = cur_reg;
        crph_next     = crph_reg;
        quoted_next   = quoted_reg;
        started_next  = started_reg;
        bcnt_next     = bcnt_reg;
        bidx_next     = bidx_reg;
        held_cr_next  = held_cr_reg;
        lhb_next      = lhb_reg;
        hdr_seen_next = hdr_seen_reg;
        fcnt_next     = fcnt_reg;
        lost_next     = lost_reg;
        store_wr      = 1'b0;
        emit          = 1'b0;
        emit_kind     = csvt_pkg::KIND_BYTE;
        emit_byte     = 8'h00;
        emit_ovf      = 1'b0;
        unique case (cmd.op)
            csvt_pkg::OP_NONE: begin
            end
            csvt_pkg::OP_LOAD: begin
                item_next = in_byte;
                eoi_next  = in_eoi;
                crph_next = load_crph;
                cur_next  = load_crph ? csvt_pkg::CH_CR : in_byte;
                if (load_crph) begin
                    held_cr_next = 1'b0;
                end
            end
            csvt_pkg::OP_HOLD_CR: begin
                held_cr_next = 1'b1;
            end
            csvt_pkg::OP_QUOTE: begin
                lhb_next    = 1'b1;
                quoted_next = !quoted_reg;
            end
            csvt_pkg::OP_BLANK: begin
                lhb_next = 1'b1;
                if (started_reg) begin
                    if (bcnt_reg < CW'(csvt_pkg::BLANK_DEPTH)) begin
                        store_wr  = 1'b1;
                        bcnt_next = bcnt_reg + CW'(1);
                    end else begin
                        lost_next = 1'b1;
                    end
                end
            end
            csvt_pkg::OP_BYTE: begin
                emit         = 1'b1;
                emit_byte    = cur_reg;
                lhb_next     = 1'b1;
                started_next = 1'b1;
                if (crph_reg) begin
                    cur_next  = item_reg;
                    crph_next = 1'b0;
                end
            end
            csvt_pkg::OP_BLANK_OUT: begin
                emit      = 1'b1;
                emit_byte = blank_rd_reg ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE;
                if (status.blank_done) begin
                    bidx_next = '0;
                    bcnt_next = '0;
                end else begin
                    bidx_next = bidx_reg + IW'(1);
                end
            end
            csvt_pkg::OP_FIELD_END: begin
                emit         = 1'b1;
                emit_kind    = csvt_pkg::KIND_FIELD_END;
                emit_ovf     = lost_reg;
                lhb_next     = 1'b1;
                started_next = 1'b0;
                bcnt_next    = '0;
                lost_next    = 1'b0;
                if (fcnt_reg != FW'(csvt_pkg::MAX_FIELDS - 1)) begin
                    fcnt_next = fcnt_reg + FW'(1);
                end
            end
            csvt_pkg::OP_ROW_END: begin
                emit          = 1'b1;
                emit_kind     = csvt_pkg::KIND_ROW_END;
                emit_ovf      = lost_reg;
                quoted_next   = 1'b0;
                started_next  = 1'b0;
                bcnt_next     = '0;
                held_cr_next  = 1'b0;
                lhb_next      = 1'b0;
                fcnt_next     = '0;
                lost_next     = 1'b0;
                hdr_seen_next = !eoi_reg;
            end
            csvt_pkg::OP_LINE_CLEAR: begin
                quoted_next  = 1'b0;
                started_next = 1'b0;
                bcnt_next    = '0;
                held_cr_next = 1'b0;
                lhb_next     = 1'b0;
                fcnt_next    = '0;
                lost_next    = 1'b0;
                if (eoi_reg) begin
                    hdr_seen_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
        ovalid_next = emit ? 1'b1 : (m_tready ? 1'b0 : ovalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crph_reg     <= 1'b0;
            quoted_reg   <= 1'b0;
            started_reg  <= 1'b0;
            bcnt_reg     <= '0;
            bidx_reg     <= '0;
            held_cr_reg  <= 1'b0;
            lhb_reg      <= 1'b0;
            hdr_seen_reg <= 1'b0;
            fcnt_reg     <= '0;
            lost_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
        end else begin
            crph_reg     <= crph_next;
            quoted_reg   <= quoted_next;
            started_reg  <= started_next;
            bcnt_reg     <= bcnt_next;
            bidx_reg     <= bidx_next;
            held_cr_reg  <= held_cr_next;
            lhb_reg      <= lhb_next;
            hdr_seen_reg <= hdr_seen_next;
            fcnt_reg     <= fcnt_next;
            lost_reg     <= lost_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        eoi_reg  <= eoi_next;
        cur_reg  <= cur_next;
        if (store_wr) begin
            blank_mem[bcnt_reg[IW-1:0]] <= (cur_reg == csvt_pkg::CH_TAB);
        end
        // read ahead at the next index so the entry is ready for the release
        blank_rd_reg <= blank_mem[bidx_next];
        if (emit) begin
            okind_reg  <= emit_kind;
            obyte_reg  <= emit_byte;
            ofield_reg <= csvt_pkg::OUT_FIELD_W'(fcnt_reg);
            ohdr_reg   <= !hdr_seen_reg;
            oovf_reg   <= emit_ovf;
            olast_reg  <= cmd.last;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {2'b00, ofield_reg, obyte_reg};
    assign m_tuser  = {oovf_reg, ohdr_reg, okind_reg};
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

@@ design/csv_field_tokenizer.sv @@
// CSV field tokenizer top: a request is taken in idle and loaded, then processed;
// a held CR is released ahead of the next request's byte, held blanks go out
// ahead of a byte, and a new request is taken only once the last one is done;
// a result waiting on m_tready stalls the sequencer.
// Reset: synchronous active-low aresetn clears line state, header flag and
// the output valid flag; the blank store is not cleared.
`default_nettype none

module csv_field_tokenizer (
    input  wire         aclk,
    input  wire         aresetn,
    // input request channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] in_byte
    input  wire         s_tuser,   // [0] end_of_input
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [13:8] field_number, [15:14] zero
    output logic [3:0]  m_tuser,   // [1:0] out_kind, [2] header_row, [3] trim_overflow
    output logic        m_tlast    // last result of the input request
);

    csvt_pkg::dp_cmd_t    cmd;
    csvt_pkg::dp_status_t status;

    // The sequencer takes one request at a time in idle; the output register
    // lets a finished result wait while the next request is already taken.
    csvt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // Datapath holds quoting, field and line state plus the blank store.
    csvt_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_byte  (s_tdata),
        .in_eoi   (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ design/csvt_checker.sv @@
// Port-level checks for csv_field_tokenizer, attached by bind.
// Depends on the top level's result ports and the kind codes in csvt_pkg.
`default_nettype none

module csvt_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata,
    input wire [3:0]  m_tuser,
    input wire        m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] == csvt_pkg::KIND_BYTE ||
                      m_tuser[1:0] == csvt_pkg::KIND_FIELD_END ||
                      m_tuser[1:0] == csvt_pkg::KIND_ROW_END))
        else $error("illegal result kind");

    a_ovf_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == csvt_pkg::KIND_BYTE |-> !m_tuser[3])
        else $error("trim overflow on a field byte");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != csvt_pkg::KIND_BYTE |->
        m_tlast && m_tdata[7:0] == 8'h00)
        else $error("field end not last or carries a byte");

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (.*);

`default_nettype wire
